### hdl/ptcd_pkg.sv
`default_nettype none
package ptcd_pkg;

    localparam int STORE_BITS     = 32;
    localparam int FIRST_DIVISOR  = 3;
    localparam int DIVISOR_STEP   = 2;

    localparam int GAP_TWO        = 2;
    localparam int GAP_FOUR       = 4;
    localparam int GAP_SIX        = 6;
    localparam int GAP_EIGHT      = 8;

    localparam int TWIN_FLOOR     = 2;
    localparam int TRIPLET_FLOOR  = 10;
    localparam int QUAD_FLOOR     = 12;

    localparam int SMALLEST_PRIME = 2;
    localparam int SECOND_PRIME   = 3;

endpackage
`default_nettype wire

### hdl/prime_test_constellation_detect.sv
`default_nettype none
// channel | signals                          | direction | item
// --------+----------------------------------+-----------+------------------------------
// in      | in_valid, in_stall, candidate     | into      | number to test
// out     | out_valid, out_stall, is_prime,   | out of    | prime flag, constellation flags,
//         | twin_hit, *_found, prior_prime_*  |           | three prior primes
//
// Zero, one, two, three and even candidates go from idle straight to the finish state.
// Odd candidates from five up run the bound check, the bit-serial remainder unit (one
// candidate bit per cycle) and the remainder test for each odd trial divisor tried, until
// a divisor hits or the square of the divisor exceeds the candidate (a prime).
// rst_n clears the sequencer, the output valid and the prime store to zero.
// A new item is taken while a result waits; finishing waits while out_stall holds it.
module prime_test_constellation_detect
    import ptcd_pkg::*;
#(
    parameter int CANDIDATE_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [CANDIDATE_BITS-1:0] candidate,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           is_prime,
    output logic                           twin_hit,
    output logic                           triplet_found,
    output logic                           quad_found,
    output logic                           cousin_found,
    output logic                           sexy_found,
    output logic [STORE_BITS-1:0]          prior_prime_one,
    output logic [STORE_BITS-1:0]          prior_prime_two,
    output logic [STORE_BITS-1:0]          prior_prime_three
);

    localparam int DIV_BITS = (CANDIDATE_BITS + 1) / 2 + 1;
    localparam int REM_BITS = DIV_BITS + 1;
    localparam int SQ_BITS  = CANDIDATE_BITS + 2;
    localparam int IDX_BITS = $clog2(CANDIDATE_BITS);
    localparam int CMP_BITS = (CANDIDATE_BITS > STORE_BITS) ? CANDIDATE_BITS : STORE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIVIDE,
        ST_NEXT,
        ST_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [CANDIDATE_BITS-1:0] n_reg, n_next;
    logic [DIV_BITS-1:0]       d_reg, d_next;
    logic [SQ_BITS-1:0]        sq_reg, sq_next;
    logic [REM_BITS-1:0]       rem_reg, rem_next;
    logic [IDX_BITS-1:0]       cnt_reg, cnt_next;
    logic                      prime_reg, prime_next;
    logic [STORE_BITS-1:0]     p1_reg, p1_next;
    logic [STORE_BITS-1:0]     p2_reg, p2_next;
    logic [STORE_BITS-1:0]     p3_reg, p3_next;
    logic                      ov_reg, ov_next;
    logic [5:0]                flags_reg, flags_next;
    logic [STORE_BITS-1:0]     o1_reg, o1_next;
    logic [STORE_BITS-1:0]     o2_reg, o2_next;
    logic [STORE_BITS-1:0]     o3_reg, o3_next;

    logic [REM_BITS-1:0]       rem_shift;
    logic [REM_BITS-1:0]       d_ext;
    logic [CMP_BITS-1:0]       n_ext;
    logic                      out_free;
    logic                      g1_two, g1_four, g1_six, g2_six, g3_eight;
    logic                      twin, trip, quad;

    function automatic logic gap_hit(input logic [CMP_BITS-1:0] p,
                                     input logic [CMP_BITS-1:0] n,
                                     input logic [CMP_BITS-1:0] g);
        gap_hit = (n >= g) && (p == n - g);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !ov_reg || !out_stall;

    assign d_ext     = REM_BITS'(d_reg);
    assign rem_shift = {rem_reg[REM_BITS-2:0], n_reg[cnt_reg]};
    assign n_ext     = CMP_BITS'(n_reg);

    assign g1_two   = gap_hit(CMP_BITS'(p1_reg), n_ext, CMP_BITS'(GAP_TWO));
    assign g1_four  = gap_hit(CMP_BITS'(p1_reg), n_ext, CMP_BITS'(GAP_FOUR));
    assign g1_six   = gap_hit(CMP_BITS'(p1_reg), n_ext, CMP_BITS'(GAP_SIX));
    assign g2_six   = gap_hit(CMP_BITS'(p2_reg), n_ext, CMP_BITS'(GAP_SIX));
    assign g3_eight = gap_hit(CMP_BITS'(p3_reg), n_ext, CMP_BITS'(GAP_EIGHT));

    assign twin = (n_ext > CMP_BITS'(TWIN_FLOOR)) && g1_two;
    assign trip = (n_ext > CMP_BITS'(TRIPLET_FLOOR)) && g2_six && (g1_two || g1_four);
    assign quad = (n_ext > CMP_BITS'(QUAD_FLOOR)) && g1_two && g2_six && g3_eight;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        prime_next = prime_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        ov_next    = ov_reg && out_stall;
        flags_next = flags_reg;
        o1_next    = o1_reg;
        o2_next    = o2_reg;
        o3_next    = o3_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = candidate;
                    d_next     = DIV_BITS'(FIRST_DIVISOR);
                    sq_next    = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
                    state_next = ST_FINISH;
                    if (candidate < CANDIDATE_BITS'(SMALLEST_PRIME))
                        prime_next = 1'b0;
                    else if (candidate == CANDIDATE_BITS'(SMALLEST_PRIME) ||
                             candidate == CANDIDATE_BITS'(SECOND_PRIME))
                        prime_next = 1'b1;
                    else if (!candidate[0])
                        prime_next = 1'b0;
                    else
                        state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sq_reg > SQ_BITS'(n_reg))
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = IDX_BITS'(CANDIDATE_BITS - 1);
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next = (rem_shift >= d_ext) ? rem_shift - d_ext : rem_shift;
                cnt_next = cnt_reg - IDX_BITS'(1);
                if (cnt_reg == '0)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (rem_reg == '0)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    d_next     = d_reg + DIV_BITS'(DIVISOR_STEP);
                    sq_next    = sq_reg + (SQ_BITS'(d_reg + DIV_BITS'(1)) << 2);
                    state_next = ST_BOUND;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    flags_next = {prime_reg && g1_six, prime_reg && g1_four,
                                  prime_reg && quad, prime_reg && trip,
                                  prime_reg && twin, prime_reg};
                    o1_next    = p1_reg;
                    o2_next    = p2_reg;
                    o3_next    = p3_reg;
                    if (prime_reg)
                    begin
                        p3_next = p2_reg;
                        p2_next = p1_reg;
                        p1_next = n_ext[STORE_BITS-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            p3_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        prime_reg <= prime_next;
        flags_reg <= flags_next;
        o1_reg    <= o1_next;
        o2_reg    <= o2_next;
        o3_reg    <= o3_next;
    end

    assign out_valid         = ov_reg;
    assign is_prime          = flags_reg[0];
    assign twin_hit          = flags_reg[1];
    assign triplet_found     = flags_reg[2];
    assign quad_found        = flags_reg[3];
    assign cousin_found      = flags_reg[4];
    assign sexy_found        = flags_reg[5];
    assign prior_prime_one   = o1_reg;
    assign prior_prime_two   = o2_reg;
    assign prior_prime_three = o3_reg;

    // trial divisor stays odd while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE || state_reg == ST_NEXT) |-> d_reg[0])
        else $error("even trial divisor");

    // partial remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT) |-> (rem_reg < d_ext))
        else $error("remainder not reduced");

    // a composite result never flags a constellation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_prime) |->
        !(twin_hit || triplet_found || quad_found || cousin_found || sexy_found))
        else $error("flag on composite");

    // the store shifts in the candidate exactly when a prime is delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free && prime_reg) |=>
        (p1_reg == $past(n_ext[STORE_BITS-1:0]) && p2_reg == $past(p1_reg)))
        else $error("prime store not updated");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FINISH) |=> $stable(p1_reg))
        else $error("prime store changed outside finish");

endmodule
`default_nettype wire
